// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/ipsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipsc_pkg
// Constants and types shared by the idle power-saving controller files.
// ----------------------------------------------------------------------------
`default_nettype none

package ipsc_pkg;

    // Timer reload values and counter limits
    localparam logic [11:0] SECONDS_PER_HOUR  = 12'd3600;
    localparam logic [7:0]  WEEK_HOURS        = 8'd168;
    localparam logic [4:0]  IDLE_PERIOD_HOURS = 5'd16;
    localparam logic [2:0]  QUALIFY_SECONDS   = 3'd5;
    localparam logic [12:0] RUN_SECONDS_CAP   = 13'd6000;
    localparam logic [7:0]  PERIOD_COUNT_MAX  = 8'd255;

    // Register reset values
    localparam logic [15:0]        DELAY_RESET      = 16'd32400;
    localparam logic signed [11:0] LOW_LIMIT_RESET  = 12'sd200;
    localparam logic signed [11:0] HIGH_LIMIT_RESET = 12'sd330;
    localparam logic [7:0]         INTENSIVE_RESET  = 8'd2;
    localparam logic [7:0]         GREEN_RESET      = 8'd4;

    // Port widths
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SMART_ENABLE   = 3'd0,
        CFG_UNUSED_ENABLE  = 3'd1,
        CFG_IDLE_DELAY     = 3'd2,
        CFG_TEMP_LOW       = 3'd3,
        CFG_TEMP_HIGH      = 3'd4,
        CFG_INTENSIVE_MAX  = 3'd5,
        CFG_GREEN_MIN      = 3'd6
    } cfg_index_t;

    // Input tuser codes
    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_KEY  = 1'b1;

endpackage

`default_nettype wire

// ===== design/idle_power_saving_controller_unit.sv =====
// ----------------------------------------------------------------------------
// idle_power_saving_controller_unit
// Idle power-saving controller: weekly usage class, temperature
// qualification and unused-saving mode, driven by ticks and key presses.
// ----------------------------------------------------------------------------
// Each input word is either a one-second tick or a key press (tuser). The
// whole update of the controller state for one word is done in the cycle the
// word is accepted, and the resulting status word is held in an output
// register from the next cycle on. One word is accepted every clock cycle
// while the input is ready, which is whenever the output register is empty
// or is being emptied in the same cycle, so the throughput is one word per
// cycle unless the result stream stalls. A tick advances the hour divider
// and the week and idle-period timers, closes the week when it runs out
// (intensive if few idle periods were seen, green if many), qualifies the
// ambient temperature against the window over five consecutive ticks and runs
// the unused-saving delay and run-time counters. A key press stops saving,
// reloads the delay and the idle timer and arms idle-period counting.
// Configuration writes take effect at once; a new idle delay is used at the
// next reload of the delay counter. All controller state is in flip-flops set
// by reset, so no start-up pass is needed; the output data register is not reset.
`default_nettype none

module idle_power_saving_controller_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [11:0] ambient_temp, [12] ambient_fault
    input  wire logic [0:0]  s_axis_tuser,   // [0] action
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [0] saving_active, [1] week_intensive,
                                             // [2] temp_in_window, [15:3] active_seconds
);

    // Configuration registers
    logic               smart_en_reg;
    logic               unused_en_reg;
    logic [15:0]        idle_delay_reg;
    logic signed [11:0] temp_low_reg;
    logic signed [11:0] temp_high_reg;
    logic [7:0]         intensive_max_reg;
    logic [7:0]         green_min_reg;

    // Controller state
    logic [11:0] hour_div_reg,   hour_div_next;
    logic [7:0]  week_left_reg,  week_left_next;
    logic [4:0]  idle_left_reg,  idle_left_next;
    logic [7:0]  period_cnt_reg, period_cnt_next;
    logic        armed_reg,      armed_next;
    logic        intensive_reg,  intensive_next;
    logic        saving_reg,     saving_next;
    logic [15:0] delay_reg,      delay_next;
    logic [12:0] run_reg,        run_next;
    logic        temp_ok_reg,    temp_ok_next;
    logic [2:0]  in_cd_reg,      in_cd_next;
    logic [2:0]  out_cd_reg,     out_cd_next;

    // Output register
    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    logic               accept;
    logic               action;
    logic signed [11:0] ambient_temp;
    logic               ambient_fault;
    logic               temp_in_range;
    logic               saving_blocked;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign action        = s_axis_tuser[0];
    assign ambient_temp  = $signed(s_axis_tdata[11:0]);
    assign ambient_fault = s_axis_tdata[12];

    // Inclusive window; an inverted window never matches
    assign temp_in_range = (ambient_temp >= temp_low_reg) && (ambient_temp <= temp_high_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smart_en_reg      <= 1'b1;
            unused_en_reg     <= 1'b1;
            idle_delay_reg    <= ipsc_pkg::DELAY_RESET;
            temp_low_reg      <= ipsc_pkg::LOW_LIMIT_RESET;
            temp_high_reg     <= ipsc_pkg::HIGH_LIMIT_RESET;
            intensive_max_reg <= ipsc_pkg::INTENSIVE_RESET;
            green_min_reg     <= ipsc_pkg::GREEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (ipsc_pkg::cfg_index_t'(cfg_addr))
                ipsc_pkg::CFG_SMART_ENABLE:  smart_en_reg      <= cfg_wdata[0];
                ipsc_pkg::CFG_UNUSED_ENABLE: unused_en_reg     <= cfg_wdata[0];
                ipsc_pkg::CFG_IDLE_DELAY:    idle_delay_reg    <= cfg_wdata;
                ipsc_pkg::CFG_TEMP_LOW:      temp_low_reg      <= $signed(cfg_wdata[11:0]);
                ipsc_pkg::CFG_TEMP_HIGH:     temp_high_reg     <= $signed(cfg_wdata[11:0]);
                ipsc_pkg::CFG_INTENSIVE_MAX: intensive_max_reg <= cfg_wdata[7:0];
                ipsc_pkg::CFG_GREEN_MIN:     green_min_reg     <= cfg_wdata[7:0];
                default:                     ; // unmapped index: drop the write
            endcase
        end
    end

    // Single-pass state update for one accepted word
    always_comb
    begin
        hour_div_next   = hour_div_reg;
        week_left_next  = week_left_reg;
        idle_left_next  = idle_left_reg;
        period_cnt_next = period_cnt_reg;
        armed_next      = armed_reg;
        intensive_next  = intensive_reg;
        saving_next     = saving_reg;
        delay_next      = delay_reg;
        run_next        = run_reg;
        temp_ok_next    = temp_ok_reg;
        in_cd_next      = in_cd_reg;
        out_cd_next     = out_cd_reg;
        saving_blocked  = 1'b0;

        if (accept)
        begin
            if (action == ipsc_pkg::ACTION_KEY)
            begin
                // Key press: stop saving and restart idle timing
                saving_next    = 1'b0;
                delay_next     = idle_delay_reg;
                run_next       = '0;
                armed_next     = 1'b1;
                idle_left_next = ipsc_pkg::IDLE_PERIOD_HOURS;
            end
            else
            begin
                // Hour divider drives the week and idle timers
                if (hour_div_reg != '0)
                begin
                    hour_div_next = hour_div_reg - 12'd1;
                end
                else
                begin
                    hour_div_next = ipsc_pkg::SECONDS_PER_HOUR;
                    if (week_left_reg != '0)
                        week_left_next = week_left_reg - 8'd1;
                    if (idle_left_reg != '0)
                        idle_left_next = idle_left_reg - 5'd1;
                end

                if (!smart_en_reg)
                begin
                    // Classification off: hold its state at reset values
                    armed_next      = 1'b0;
                    period_cnt_next = '0;
                    intensive_next  = 1'b0;
                    hour_div_next   = ipsc_pkg::SECONDS_PER_HOUR;
                    week_left_next  = ipsc_pkg::WEEK_HOURS;
                    idle_left_next  = ipsc_pkg::IDLE_PERIOD_HOURS;
                end
                else
                begin
                    if (week_left_next == '0)
                    begin
                        // End of week: classify, green wins when both match
                        if (period_cnt_reg <= intensive_max_reg)
                            intensive_next = 1'b1;
                        if (period_cnt_reg >= green_min_reg)
                            intensive_next = 1'b0;
                        week_left_next  = ipsc_pkg::WEEK_HOURS;
                        period_cnt_next = '0;
                        saving_next     = 1'b0;
                        delay_next      = idle_delay_reg;
                        run_next        = '0;
                        armed_next      = 1'b1;
                        idle_left_next  = ipsc_pkg::IDLE_PERIOD_HOURS;
                    end

                    if (armed_next && (idle_left_next == '0))
                    begin
                        if (period_cnt_next != ipsc_pkg::PERIOD_COUNT_MAX)
                            period_cnt_next = period_cnt_next + 8'd1;
                        armed_next = 1'b0;
                    end
                end

                // Temperature qualification over consecutive ticks
                if (temp_in_range)
                begin
                    if (in_cd_reg != '0)
                        in_cd_next = in_cd_reg - 3'd1;
                    out_cd_next = ipsc_pkg::QUALIFY_SECONDS;
                end
                else
                begin
                    if (out_cd_reg != '0)
                        out_cd_next = out_cd_reg - 3'd1;
                    in_cd_next = ipsc_pkg::QUALIFY_SECONDS;
                end
                if (in_cd_next == '0)
                    temp_ok_next = 1'b1;
                else if (out_cd_next == '0)
                    temp_ok_next = 1'b0;

                // Unused-saving mode
                if (!unused_en_reg || intensive_next || ambient_fault)
                begin
                    saving_next = 1'b0;
                    delay_next  = idle_delay_reg;
                    run_next    = '0;
                end
                else
                begin
                    if (saving_next)
                    begin
                        if (run_next < ipsc_pkg::RUN_SECONDS_CAP)
                            run_next = run_next + 13'd1;
                        if (!temp_ok_next)
                        begin
                            saving_blocked = 1'b1;
                            saving_next    = 1'b0;
                            delay_next     = idle_delay_reg;
                            run_next       = '0;
                        end
                    end
                    if (!saving_blocked)
                    begin
                        if (delay_next != '0)
                            delay_next = delay_next - 16'd1;
                        else if (temp_ok_next)
                            saving_next = 1'b1;
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_div_reg   <= ipsc_pkg::SECONDS_PER_HOUR;
            week_left_reg  <= ipsc_pkg::WEEK_HOURS;
            idle_left_reg  <= ipsc_pkg::IDLE_PERIOD_HOURS;
            period_cnt_reg <= '0;
            armed_reg      <= 1'b0;
            intensive_reg  <= 1'b0;
            saving_reg     <= 1'b0;
            delay_reg      <= ipsc_pkg::DELAY_RESET;
            run_reg        <= '0;
            temp_ok_reg    <= 1'b1;
            in_cd_reg      <= ipsc_pkg::QUALIFY_SECONDS;
            out_cd_reg     <= ipsc_pkg::QUALIFY_SECONDS;
        end
        else
        begin
            hour_div_reg   <= hour_div_next;
            week_left_reg  <= week_left_next;
            idle_left_reg  <= idle_left_next;
            period_cnt_reg <= period_cnt_next;
            armed_reg      <= armed_next;
            intensive_reg  <= intensive_next;
            saving_reg     <= saving_next;
            delay_reg      <= delay_next;
            run_reg        <= run_next;
            temp_ok_reg    <= temp_ok_next;
            in_cd_reg      <= in_cd_next;
            out_cd_reg     <= out_cd_next;
        end
    end

    // Output register: load on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {run_next, temp_ok_next, intensive_next, saving_next};
        end
    end

endmodule

`default_nettype wire

// ===== design/ipsc_checker.sv =====
// ----------------------------------------------------------------------------
// ipsc_checker
// Port-level checks for the idle power-saving controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ipsc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [0:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    // Stalled result holds
    `ASSERT_NEXT_CYCLE(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Run time never passes its cap
    `ASSERT_SAME_CYCLE(a_run_cap, clk, rst_n, m_axis_tvalid, m_axis_tdata[15:3] <= ipsc_pkg::RUN_SECONDS_CAP)

    // Saving never runs in an intensive week or outside the window
    `ASSERT_SAME_CYCLE(a_saving_ok, clk, rst_n, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[1] && m_axis_tdata[2])

    // A key press stops saving and clears its run time
    `ASSERT_NEXT_CYCLE(a_key_stop, clk, rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ipsc_pkg::ACTION_KEY), m_axis_tvalid && !m_axis_tdata[0] && (m_axis_tdata[15:3] == 13'd0))

endmodule

bind idle_power_saving_controller_unit ipsc_checker u_ipsc_checker (.*);

`default_nettype wire
